// File: rtl/core/afdcs_pkg.sv
`timescale 1ns / 1ps
// Package for the auxiliary frame to DMX channel store block.
// Holds payload structs, codes, constants and the FSM type; depends on nothing.
package afdcs_pkg;

	localparam int CHANNELS_DEF     = 512;
	localparam int MIN_CHANNELS_DEF = 6;
	localparam int PAIR_DEPTH       = 256;
	localparam int PAIR_AW          = 8;
	localparam logic [9:0] COUNT_MAX = 10'd1023;
	localparam logic [9:0] V1_HDR   = 10'd7;
	localparam logic [9:0] V2_HDR   = 10'd9;
	localparam logic [7:0] MAGIC_0  = 8'h56;
	localparam logic [7:0] MAGIC_1  = 8'h41;
	localparam logic [7:0] MAGIC_2  = 8'h55;
	localparam logic [7:0] MAGIC_3  = 8'h58;
	localparam logic [7:0] VER_1    = 8'h01;
	localparam logic [7:0] VER_2    = 8'h02;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_BAD_HDR = 2'd1;
	localparam logic [1:0] STAT_BAD_LEN = 2'd2;

	localparam logic [1:0] REG_LASER  = 2'd0;
	localparam logic [1:0] REG_STROBE = 2'd1;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic       last_byte;
		logic [9:0] read_channel;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [9:0] send_count;
		logic       strobe_level;
		logic [7:0] read_value;
	} out_item_t;

	typedef struct packed {
		logic [8:0][7:0] hdr;
		logic [9:0]      len;
	} hdr_info_t;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_EVAL, S_CLEAR, S_APPLY, S_DRAIN, S_FINISH, S_READ, S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		CM_INIT, CM_FRAME, CM_ITEM
	} clr_mode_t;

endpackage

// File: rtl/core/afdcs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the channel store and the pair buffer.
module afdcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/core/afdcs_rx.sv
`timescale 1ns / 1ps
// Frame byte intake: byte counter, header registers and pair buffer.
// Depends on afdcs_pkg and afdcs_ram.
module afdcs_rx (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	input  logic [7:0]            byte_data,
	input  logic                  frame_clear,
	input  logic [afdcs_pkg::PAIR_AW-1:0] pair_raddr,
	output logic [23:0]           pair_rdata,
	output afdcs_pkg::hdr_info_t  info
);
	logic [9:0]      cnt_q;
	logic [8:0][7:0] hdr_q;
	logic [1:0]      part_q;
	logic [8:0]      idx_q;
	logic [15:0]     lo_q;
	logic [9:0]      hl;
	logic            in_pairs;
	logic [1:0]      cur_part;
	logic [8:0]      cur_idx;
	logic            pb_we;

	always_comb begin
		if (hdr_q[4] == afdcs_pkg::VER_1) begin
			hl = afdcs_pkg::V1_HDR;
		end else if (hdr_q[4] == afdcs_pkg::VER_2) begin
			hl = afdcs_pkg::V2_HDR;
		end else begin
			hl = '0;
		end
		in_pairs = (hl != '0) && (cnt_q >= hl) && (cnt_q > 10'd4);
		cur_part = (cnt_q == hl) ? 2'd0 : part_q;
		cur_idx  = (cnt_q == hl) ? 9'd0 : idx_q;
		pb_we    = byte_valid && in_pairs && (cur_part == 2'd2) && !cur_idx[8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			hdr_q  <= '0;
			part_q <= '0;
			idx_q  <= '0;
		end else if (frame_clear) begin
			cnt_q <= '0;
			hdr_q <= '0;
		end else if (byte_valid) begin
			for (int k = 0; k < 9; k++) begin
				if (cnt_q == 10'(k)) begin
					hdr_q[k] <= byte_data;
				end
			end
			if (in_pairs) begin
				if (cur_part == 2'd2) begin
					part_q <= 2'd0;
					idx_q  <= cur_idx[8] ? cur_idx : cur_idx + 9'd1;
				end else begin
					part_q <= cur_part + 2'd1;
					idx_q  <= cur_idx;
				end
			end
			if (cnt_q != afdcs_pkg::COUNT_MAX) begin
				cnt_q <= cnt_q + 10'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && in_pairs) begin
			if (cur_part == 2'd0) begin
				lo_q[7:0] <= byte_data;
			end else if (cur_part == 2'd1) begin
				lo_q[15:8] <= byte_data;
			end
		end
	end

	afdcs_ram #(.WIDTH(24), .DEPTH(afdcs_pkg::PAIR_DEPTH)) u_pair_ram (
		.clk   (clk),
		.we    (pb_we),
		.waddr (cur_idx[afdcs_pkg::PAIR_AW-1:0]),
		.wdata ({byte_data, lo_q}),
		.raddr (pair_raddr),
		.rdata (pair_rdata)
	);

	assign info.hdr = hdr_q;
	assign info.len = cnt_q;
endmodule

// File: rtl/core/aux_frame_to_dmx_channel_store_core.sv
`timescale 1ns / 1ps
// Top level of the auxiliary frame to DMX channel store block.
// Depends on afdcs_pkg, afdcs_ram and afdcs_rx.

// This block receives VAUX frames one byte per transaction and keeps a channel
// store of CHANNELS bytes in a RAM with one write port and a registered read port.
// A frame byte that is not the last gives no result. The last byte of a frame is
// checked in the cycle after it is accepted; a valid frame then clears the store
// with a sweep, one entry per cycle, and, with the laser output enabled, replays
// its buffered pairs from the pair RAM at one pair per cycle. A read transaction
// waits for the registered RAM read, and a clear transaction runs the same sweep.
// After reset the store is cleared by the same sweep, during which no input
// transaction is accepted; configuration writes are accepted at any time.
// Results wait in an output register, so frame bytes keep flowing while a result
// is not yet taken.
module aux_frame_to_dmx_channel_store_core #(
	parameter int CHANNELS     = afdcs_pkg::CHANNELS_DEF,
	parameter int MIN_CHANNELS = afdcs_pkg::MIN_CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  afdcs_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output afdcs_pkg::out_item_t out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [0:0]           cfg_data
);
	localparam int AW = $clog2(CHANNELS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(CHANNELS - 1);
	localparam logic [9:0]  CH_MAX  = 10'(CHANNELS);
	localparam logic [15:0] CH_MAX16 = 16'(CHANNELS);
	localparam logic [15:0] MIN16   = 16'(MIN_CHANNELS);

	afdcs_pkg::state_t    st_q, st_nxt;
	afdcs_pkg::clr_mode_t mode_q;
	afdcs_pkg::hdr_info_t info;

	logic            laser_q, strobe_en_q;
	logic [9:0]      cur_cnt_q;
	logic            strobe_q;
	logic [AW-1:0]   sweep_q;
	logic [7:0]      pairs_q;
	logic [7:0]      ap_idx_q;
	logic            ap_v_s1;
	logic [9:0]      high_q;
	logic            full_q, fr_strobe_q;
	logic [15:0]     req_q;
	logic [1:0]      res_status_q;
	logic [7:0]      res_value_q;
	logic            rd_ok_q;
	logic            out_valid_q;
	afdcs_pkg::out_item_t out_q;

	logic in_acc, byte_acc, frame_clear, emit_go;
	logic [1:0] ev_status;
	logic ev_strobe, ev_full;
	logic [15:0] ev_req;
	logic [9:0]  ev_hl;
	logic [23:0] pair_rdata;
	logic [15:0] ap_ch;
	logic        ap_hit;
	logic        st_we;
	logic [AW-1:0] st_waddr, st_raddr;
	logic [7:0]  st_wdata, st_rdata;
	logic [15:0] cnt_m;
	logic        rd_in_range;

	assign cfg_ready = 1'b1;
	assign in_ready  = (st_q == afdcs_pkg::S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign byte_acc  = in_acc && (in_data.kind == afdcs_pkg::KIND_BYTE);
	assign emit_go   = !out_valid_q || out_ready;
	assign frame_clear = (st_q == afdcs_pkg::S_EVAL);
	assign rd_in_range = (in_data.read_channel != 10'd0) && (in_data.read_channel <= CH_MAX);

	// Header check of the completed frame; the last byte is already in the registers.
	always_comb begin
		ev_status = afdcs_pkg::STAT_OK;
		ev_strobe = 1'b0;
		ev_full   = 1'b1;
		ev_req    = CH_MAX16;
		ev_hl     = afdcs_pkg::V1_HDR;
		if (info.len < afdcs_pkg::V1_HDR || info.hdr[0] != afdcs_pkg::MAGIC_0 ||
		    info.hdr[1] != afdcs_pkg::MAGIC_1 || info.hdr[2] != afdcs_pkg::MAGIC_2 ||
		    info.hdr[3] != afdcs_pkg::MAGIC_3) begin
			ev_status = afdcs_pkg::STAT_BAD_HDR;
		end else if (info.hdr[4] == afdcs_pkg::VER_1) begin
			ev_strobe = (info.hdr[5] != 8'd0);
		end else if (info.hdr[4] == afdcs_pkg::VER_2) begin
			ev_hl     = afdcs_pkg::V2_HDR;
			ev_strobe = info.hdr[5][0];
			ev_full   = info.hdr[5][1];
			ev_req    = {info.hdr[8], info.hdr[7]};
			if (info.len < afdcs_pkg::V2_HDR) begin
				ev_status = afdcs_pkg::STAT_BAD_HDR;
			end
		end else begin
			ev_status = afdcs_pkg::STAT_BAD_HDR;
		end
		if (ev_status == afdcs_pkg::STAT_OK &&
		    info.len != ev_hl + 10'({2'b00, info.hdr[6]} * 10'd3)) begin
			ev_status = afdcs_pkg::STAT_BAD_LEN;
		end
	end

	// Send count for a frame that is not in full mode.
	always_comb begin
		cnt_m = req_q;
		if (cnt_m < MIN16) begin
			cnt_m = MIN16;
		end
		if (cnt_m < {6'd0, high_q}) begin
			cnt_m = {6'd0, high_q};
		end
		if (cnt_m > CH_MAX16) begin
			cnt_m = CH_MAX16;
		end
	end

	// Pair replay: the channel field of the pair that left the pair RAM this cycle.
	assign ap_ch  = pair_rdata[15:0];
	assign ap_hit = ap_v_s1 && (ap_ch != 16'd0) && (ap_ch <= CH_MAX16);

	// Next state.
	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			afdcs_pkg::S_INIT: begin
				if (sweep_q == LAST_ADDR) st_nxt = afdcs_pkg::S_IDLE;
			end
			afdcs_pkg::S_IDLE: begin
				if (in_acc) begin
					case (in_data.kind)
						afdcs_pkg::KIND_BYTE:  if (in_data.last_byte) st_nxt = afdcs_pkg::S_EVAL;
						afdcs_pkg::KIND_READ:  st_nxt = afdcs_pkg::S_READ;
						afdcs_pkg::KIND_CLEAR: st_nxt = afdcs_pkg::S_CLEAR;
						default:               st_nxt = afdcs_pkg::S_IDLE;
					endcase
				end
			end
			afdcs_pkg::S_EVAL: begin
				st_nxt = (ev_status == afdcs_pkg::STAT_OK) ? afdcs_pkg::S_CLEAR
				                                          : afdcs_pkg::S_EMIT;
			end
			afdcs_pkg::S_CLEAR: begin
				if (sweep_q == LAST_ADDR) begin
					if (mode_q == afdcs_pkg::CM_ITEM) begin
						st_nxt = afdcs_pkg::S_EMIT;
					end else if (laser_q && pairs_q != 8'd0) begin
						st_nxt = afdcs_pkg::S_APPLY;
					end else begin
						st_nxt = afdcs_pkg::S_FINISH;
					end
				end
			end
			afdcs_pkg::S_APPLY: begin
				if (ap_idx_q == pairs_q - 8'd1) st_nxt = afdcs_pkg::S_DRAIN;
			end
			afdcs_pkg::S_DRAIN:  st_nxt = afdcs_pkg::S_FINISH;
			afdcs_pkg::S_FINISH: st_nxt = afdcs_pkg::S_EMIT;
			afdcs_pkg::S_READ:   st_nxt = afdcs_pkg::S_EMIT;
			afdcs_pkg::S_EMIT: begin
				if (emit_go) st_nxt = afdcs_pkg::S_IDLE;
			end
			default: st_nxt = afdcs_pkg::S_IDLE;
		endcase
	end

	// Channel store port control.
	always_comb begin
		st_we    = 1'b0;
		st_waddr = sweep_q;
		st_wdata = 8'd0;
		st_raddr = AW'(in_data.read_channel - 10'd1);
		unique case (st_q)
			afdcs_pkg::S_INIT, afdcs_pkg::S_CLEAR: begin
				st_we = 1'b1;
			end
			default: begin
				st_we    = ap_hit;
				st_waddr = AW'(ap_ch - 16'd1);
				st_wdata = pair_rdata[23:16];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= afdcs_pkg::S_INIT;
			mode_q      <= afdcs_pkg::CM_INIT;
			laser_q     <= 1'b0;
			strobe_en_q <= 1'b0;
			cur_cnt_q   <= 10'(MIN_CHANNELS);
			strobe_q    <= 1'b0;
			sweep_q     <= '0;
			ap_idx_q    <= '0;
			ap_v_s1     <= 1'b0;
			high_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == afdcs_pkg::REG_LASER)  laser_q     <= cfg_data[0];
				if (cfg_index == afdcs_pkg::REG_STROBE) strobe_en_q <= cfg_data[0];
			end
			if (st_q == afdcs_pkg::S_INIT || st_q == afdcs_pkg::S_CLEAR) begin
				sweep_q <= (sweep_q == LAST_ADDR) ? '0 : sweep_q + AW'(1);
			end
			if (in_acc && in_data.kind == afdcs_pkg::KIND_CLEAR) begin
				mode_q <= afdcs_pkg::CM_ITEM;
			end
			if (st_q == afdcs_pkg::S_EVAL) begin
				mode_q   <= afdcs_pkg::CM_FRAME;
				high_q   <= '0;
				ap_idx_q <= '0;
			end
			if (st_q == afdcs_pkg::S_CLEAR && sweep_q == LAST_ADDR &&
			    mode_q == afdcs_pkg::CM_ITEM) begin
				cur_cnt_q <= 10'(MIN_CHANNELS);
				if (strobe_en_q) strobe_q <= 1'b0;
			end
			ap_v_s1 <= (st_q == afdcs_pkg::S_APPLY);
			if (st_q == afdcs_pkg::S_APPLY) begin
				ap_idx_q <= ap_idx_q + 8'd1;
			end
			if (ap_hit && ap_ch[9:0] > high_q) begin
				high_q <= ap_ch[9:0];
			end
			if (st_q == afdcs_pkg::S_FINISH) begin
				cur_cnt_q <= full_q ? CH_MAX : cnt_m[9:0];
				if (strobe_en_q) strobe_q <= fr_strobe_q;
			end
			if (st_q == afdcs_pkg::S_EMIT && emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_status_q <= afdcs_pkg::STAT_OK;
			rd_ok_q      <= rd_in_range;
		end
		if (st_q == afdcs_pkg::S_EVAL) begin
			res_status_q <= ev_status;
			full_q       <= ev_full;
			fr_strobe_q  <= ev_strobe;
			req_q        <= ev_req;
			pairs_q      <= info.hdr[6];
		end
		// The input may already carry the next transaction here, so only the
		// range flag captured at acceptance decides.
		if (st_q == afdcs_pkg::S_READ) begin
			res_value_q <= rd_ok_q ? st_rdata : 8'd0;
		end else if (st_q != afdcs_pkg::S_EMIT) begin
			res_value_q <= 8'd0;
		end
		if (st_q == afdcs_pkg::S_EMIT && emit_go) begin
			out_q.status       <= res_status_q;
			out_q.send_count   <= cur_cnt_q;
			out_q.strobe_level <= strobe_q;
			out_q.read_value   <= res_value_q;
		end
	end

	afdcs_rx u_rx (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_acc),
		.byte_data   (in_data.data_byte),
		.frame_clear (frame_clear),
		.pair_raddr  (ap_idx_q),
		.pair_rdata  (pair_rdata),
		.info        (info)
	);

	afdcs_ram #(.WIDTH(8), .DEPTH(CHANNELS)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The store is never written while a read waits for its data.
	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == afdcs_pkg::S_READ |-> !st_we)
		else $error("channel store written during a read");

	// Pair replay only happens with the laser output enabled.
	a_apply_laser: assert property (@(posedge clk) disable iff (!arst_n)
		ap_v_s1 |-> laser_q)
		else $error("pair applied with laser disabled");

	// The send count stays within its legal range.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_cnt_q >= 10'(MIN_CHANNELS) && cur_cnt_q <= CH_MAX)
		else $error("send count out of range");

	// A result is only produced after the emit state was taken.
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == afdcs_pkg::S_EMIT))
		else $error("result loaded outside emit");
endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the auxiliary frame to DMX channel store block.
// Depends on afdcs_pkg and aux_frame_to_dmx_channel_store_core; holds the scoreboard.

import afdcs_pkg::*;

class frame_scoreboard;
	// Configuration and state mirrored from the block.
	bit        laser_en;
	bit        strobe_en;
	bit [7:0]  chan_mem [512];
	bit [23:0] pair_mem [256];
	int        byte_cnt;
	bit [7:0]  hdr_mem [9];
	int        cur_count;
	bit        strobe_q;
	out_item_t pending_q [$];
	int        err_cnt;

	function new();
		foreach (chan_mem[i]) chan_mem[i] = 0;
		foreach (pair_mem[i]) pair_mem[i] = 0;
		foreach (hdr_mem[i]) hdr_mem[i] = 0;
		byte_cnt = 0;
		cur_count = MIN_CHANNELS_DEF;
		strobe_q = 0;
		err_cnt = 0;
	endfunction

	function void set_reg(bit [1:0] idx, bit val);
		if (idx == REG_LASER) laser_en = val;
		else if (idx == REG_STROBE) strobe_en = val;
	endfunction

	// Checks a completed frame and applies it when it is well formed.
	function bit [1:0] commit(int len);
		int hl, pairs, req, high, cnt, ch;
		bit full, strb;
		high = 0;
		if (len < 7 || hdr_mem[0] != MAGIC_0 || hdr_mem[1] != MAGIC_1 ||
				hdr_mem[2] != MAGIC_2 || hdr_mem[3] != MAGIC_3)
			return STAT_BAD_HDR;
		if (hdr_mem[4] == VER_1) begin
			hl = 7;
			strb = hdr_mem[5] != 0;
			full = 1;
			req = CHANNELS_DEF;
		end else if (hdr_mem[4] == VER_2) begin
			if (len < 9)
				return STAT_BAD_HDR;
			hl = 9;
			strb = hdr_mem[5][0];
			full = hdr_mem[5][1];
			req = {hdr_mem[8], hdr_mem[7]};
		end else begin
			return STAT_BAD_HDR;
		end
		pairs = hdr_mem[6];
		if (len != hl + pairs * 3)
			return STAT_BAD_LEN;
		foreach (chan_mem[i]) chan_mem[i] = 0;
		if (laser_en) begin
			for (int i = 0; i < pairs; i++) begin
				ch = pair_mem[i][15:0];
				if (ch == 0 || ch > CHANNELS_DEF)
					continue;
				chan_mem[ch - 1] = pair_mem[i][23:16];
				if (ch > high) high = ch;
			end
		end
		if (full) begin
			cnt = CHANNELS_DEF;
		end else begin
			cnt = req;
			if (cnt < MIN_CHANNELS_DEF) cnt = MIN_CHANNELS_DEF;
			if (cnt < high) cnt = high;
			if (cnt > CHANNELS_DEF) cnt = CHANNELS_DEF;
		end
		cur_count = cnt;
		if (strobe_en) strobe_q = strb;
		return STAT_OK;
	endfunction

	// Notes an accepted input transaction and queues the result it causes.
	function void note_input(in_item_t it);
		out_item_t r;
		int hl, off, idx;
		r = '0;
		if (it.kind == KIND_BYTE) begin
			hl = hdr_mem[4] == VER_1 ? 7 : (hdr_mem[4] == VER_2 ? 9 : 0);
			if (byte_cnt < 9) hdr_mem[byte_cnt] = it.data_byte;
			if (hl != 0 && byte_cnt >= hl && byte_cnt > 4) begin
				off = byte_cnt - hl;
				idx = off / 3;
				if (idx < 256) pair_mem[idx][8 * (off % 3) +: 8] = it.data_byte;
			end
			if (byte_cnt < 1023) byte_cnt++;
			if (!it.last_byte) return;
			r.status = commit(byte_cnt);
			byte_cnt = 0;
			foreach (hdr_mem[i]) hdr_mem[i] = 0;
		end else if (it.kind == KIND_READ) begin
			if (it.read_channel >= 1 && it.read_channel <= CHANNELS_DEF)
				r.read_value = chan_mem[it.read_channel - 1];
		end else if (it.kind == KIND_CLEAR) begin
			foreach (chan_mem[i]) chan_mem[i] = 0;
			cur_count = MIN_CHANNELS_DEF;
			if (strobe_en) strobe_q = 0;
		end else begin
			return;
		end
		r.send_count = 10'(cur_count);
		r.strobe_level = strobe_q;
		pending_q.push_back(r);
	endfunction

	function void check_result(out_item_t got);
		out_item_t exp;
		if (pending_q.size() == 0) begin
			$error("unexpected result %h", got);
			err_cnt++;
			return;
		end
		exp = pending_q.pop_front();
		if (got.status !== exp.status) begin
			$error("status: expected %0d, got %0d", exp.status, got.status);
			err_cnt++;
		end
		if (got.send_count !== exp.send_count) begin
			$error("send_count: expected %0d, got %0d", exp.send_count, got.send_count);
			err_cnt++;
		end
		if (got.strobe_level !== exp.strobe_level) begin
			$error("strobe_level: expected %0d, got %0d", exp.strobe_level,
				got.strobe_level);
			err_cnt++;
		end
		if (got.read_value !== exp.read_value) begin
			$error("read_value: expected %0d, got %0d", exp.read_value, got.read_value);
			err_cnt++;
		end
	endfunction
endclass

module tb_top;
	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [1:0] cfg_index;
	logic [0:0] cfg_data;

	frame_scoreboard sb;
	// While this flag is set neither side inserts idle cycles.
	bit no_idle;
	int item_cnt;

	aux_frame_to_dmx_channel_store_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// The run is bounded generously: even if every transaction of the run were as
	// slow as the slowest kind, a valid frame, under heavy stalls, the run would
	// stay well below this.
	initial begin
		#100_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Sends one input transaction. Valid stays high until the transaction is
	// accepted, and the scoreboard notes it at the accepting edge. Valid is left
	// high afterwards; an idle cycle or drain() drops it.
	task automatic send_item(in_item_t it);
		while (!no_idle && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_input(it);
		item_cnt++;
	endtask

	task automatic send_byte(bit [7:0] b, bit last);
		in_item_t it;
		it = '0;
		it.kind = KIND_BYTE;
		it.data_byte = b;
		it.last_byte = last;
		it.read_channel = 10'($urandom_range(1023));
		send_item(it);
	endtask

	task automatic send_read(bit [9:0] ch);
		in_item_t it;
		it = '0;
		it.kind = KIND_READ;
		it.read_channel = ch;
		it.data_byte = 8'($urandom);
		it.last_byte = 1'($urandom);
		send_item(it);
	endtask

	task automatic send_clear();
		in_item_t it;
		it = '0;
		it.kind = KIND_CLEAR;
		it.data_byte = 8'($urandom);
		it.last_byte = 1'($urandom);
		it.read_channel = 10'($urandom_range(1023));
		send_item(it);
	endtask

	// Sends a whole frame from a byte list; the final byte carries the mark.
	task automatic send_frame(bit [7:0] bytes [$]);
		foreach (bytes[i])
			send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	// Builds a frame. Version 1 or 2, a flags byte, a requested count and a
	// number of pairs; len_delta adds or drops trailing bytes to break the length.
	task automatic build_frame(output bit [7:0] q [$], input bit [7:0] ver,
			input bit [7:0] flags, input bit [15:0] req, input int pairs,
			input int len_delta, input bit wide_ch);
		bit [15:0] ch;
		q = {MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3, ver, flags, 8'(pairs)};
		if (ver == VER_2) begin
			q.push_back(req[7:0]);
			q.push_back(req[15:8]);
		end
		for (int i = 0; i < pairs; i++) begin
			ch = wide_ch ? 16'($urandom) : 16'($urandom_range(520));
			q.push_back(ch[7:0]);
			q.push_back(ch[15:8]);
			q.push_back(8'($urandom));
		end
		if (len_delta > 0)
			repeat (len_delta) q.push_back(8'($urandom));
		else if (len_delta < 0)
			repeat (-len_delta) if (q.size() > 1) void'(q.pop_back());
	endtask

	// Writes a configuration register. The scoreboard follows at the accepting
	// edge; valid is dropped after each write before the task returns.
	task automatic write_reg(bit [1:0] idx, bit val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drops input valid, waits until every expected result has arrived, then lets
	// the block settle for a span longer than its slowest transaction.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (1200) @(posedge clk);
	endtask

	// Receiver: ready idles at random unless no_idle is set, and every accepted result is checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(out_data);
			out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 15);
		end
	end

	task automatic random_traffic(int count);
		bit [7:0] fq [$];
		int sel, pairs;
		bit [7:0] ver;
		while (item_cnt < count) begin
			sel = $urandom_range(99);
			ver = $urandom_range(1) ? VER_2 : VER_1;
			// Most frames use few pairs; a rare one is large.
			pairs = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(6);
			if (sel < 55) begin
				build_frame(fq, ver, 8'($urandom), $urandom_range(1) ? 16'($urandom) :
					16'($urandom_range(20)), pairs, 0, $urandom_range(9) == 0);
				send_frame(fq);
			end else if (sel < 62) begin
				build_frame(fq, ver, 8'($urandom), 16'($urandom), pairs,
					$urandom_range(1) ? 1 : -1, 1'b0);
				send_frame(fq);
			end else if (sel < 67) begin
				// Broken header: one header byte is corrupted.
				build_frame(fq, ver, 8'($urandom), 16'($urandom), pairs, 0, 1'b0);
				fq[$urandom_range(4)] = 8'($urandom);
				send_frame(fq);
			end else if (sel < 72) begin
				repeat ($urandom_range(1, 12)) send_byte(8'($urandom), 1'b0);
				send_byte(8'($urandom), 1'b1);
			end else if (sel < 92) begin
				send_read($urandom_range(3) == 0 ? 10'($urandom_range(1023)) :
					10'($urandom_range(520)));
			end else if (sel < 96) begin
				send_clear();
			end else begin
				send_item('{kind: 2'd3, data_byte: 8'($urandom), last_byte: 1'($urandom),
					read_channel: 10'($urandom_range(1023))});
				item_cnt--;
			end
		end
	endtask

	initial begin
		bit [7:0] fq [$];
		sb = new();
		no_idle = 0;
		item_cnt = 0;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_ready = 0;
		cfg_valid = 0;
		cfg_index = REG_LASER;
		cfg_data = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with both features off, then on.
		build_frame(fq, VER_1, 8'h01, 16'd0, 2, 0, 1'b0);
		send_frame(fq);
		send_read(10'd0);
		drain();
		write_reg(REG_LASER, 1'b1);
		write_reg(REG_STROBE, 1'b1);
		// Version 1 with pairs at channel 1 and channel 512.
		fq = {MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3, VER_1, 8'hFF, 8'd2,
			8'h01, 8'h00, 8'hFF, 8'h00, 8'h02, 8'hA5};
		send_frame(fq);
		send_read(10'd1);
		send_read(10'd512);
		send_read(10'd513);
		send_read(10'd1023);
		// Version 2, not full, requested count below the minimum, pair at 513.
		fq = {MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3, VER_2, 8'h00, 8'd1, 8'h02, 8'h00,
			8'h01, 8'h02, 8'h77};
		send_frame(fq);
		// Version 2, full mode and a huge requested count, no pairs.
		fq = {MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3, VER_2, 8'h03, 8'd0, 8'hFF, 8'hFF};
		send_frame(fq);
		send_clear();
		// Bad version, short frame, length mismatch.
		fq = {MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3, 8'h03, 8'h00, 8'h00};
		send_frame(fq);
		fq = {MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3, VER_2, 8'h00, 8'h00, 8'h00};
		send_frame(fq);
		send_byte(8'h00, 1'b1);
		build_frame(fq, VER_2, 8'h01, 16'd40, 3, 1, 1'b0);
		send_frame(fq);
		drain();

		// A frame longer than the counter can hold must fail the length check.
		no_idle = 1;
		build_frame(fq, VER_1, 8'h00, 16'd0, 255, 300, 1'b0);
		send_frame(fq);
		drain();
		no_idle = 0;

		// Random phases over every register setting but both off; one phase runs without idling.
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_LASER, ph[0]);
			write_reg(REG_STROBE, ph[1] | (ph == 0));
			no_idle = (ph == 2);
			random_traffic(item_cnt + 220);
			drain();
		end
		no_idle = 0;

		if (sb.err_cnt == 0 && sb.pending_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// File: sim.f
rtl/core/afdcs_pkg.sv
rtl/core/afdcs_ram.sv
rtl/core/afdcs_rx.sv
rtl/core/aux_frame_to_dmx_channel_store_core.sv
bench/tb_top.sv
